>>> hdl/sitda_pkg.sv
// ============================================================================
// sitda_pkg
// Shared types and constants for the signed integer to decimal text unit.
// ============================================================================
package sitda_pkg;

    // input word and decimal widths
    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CHAR_W   = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 8'd45;

    // converted magnitude handed from the shift-add stage to the emitter
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } conv_result_t;

    // emitter sequencing
    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_SIGN,
        EM_DIGIT
    } emit_state_t;

endpackage

>>> hdl/sitda_dabble.sv
// ============================================================================
// sitda_dabble
// Bit-serial binary to BCD conversion of the magnitude, one bit per cycle.
// ============================================================================
module sitda_dabble
    import sitda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [VALUE_W-1:0] value,
    output conv_result_t       result
);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic [BCD_W-1:0]   bcd_adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // load, shift and count
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (load)
        begin
            neg_next = value[VALUE_W-1];
            bin_next = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            bcd_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(VALUE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign result.valid = done_reg;
    assign result.neg   = neg_reg;
    assign result.bcd   = bcd_reg;

    // a finished conversion never reports while still shifting
    a_done_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg)
        else $error("conversion reported while still running");

    // a conversion reports in the cycle after its final step
    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !load && cnt_reg == 5'(VALUE_W - 1)) |=> done_reg)
        else $error("conversion end not reported");

endmodule

>>> hdl/sitda_emitter.sv
// ============================================================================
// sitda_emitter
// Walks the BCD digits from the top, drops leading zeros, emits characters.
// ============================================================================
module sitda_emitter
    import sitda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  conv_result_t      conv,
    output logic [CHAR_W-1:0] char_code,
    output logic              last,
    output logic              strobe
);

    emit_state_t       state_reg, state_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              strobe_reg, strobe_next;
    logic [3:0]        top_digit;

    assign top_digit = dig_reg[BCD_W-1 -: 4];

    // next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        char_next   = char_reg;
        last_next   = 1'b0;
        strobe_next = 1'b0;
        case (state_reg)
            EM_IDLE:
            begin
                if (conv.valid)
                begin
                    dig_next   = conv.bcd;
                    neg_next   = conv.neg;
                    cnt_next   = 4'(DIGITS);
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP:
            begin
                // keep at least one digit so zero prints as a single 0
                if (top_digit == 4'd0 && cnt_reg > 4'd1)
                begin
                    dig_next = {dig_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 4'd1;
                end
                else if (neg_reg)
                    state_next = EM_SIGN;
                else
                    state_next = EM_DIGIT;
            end
            EM_SIGN:
            begin
                char_next   = CODE_MINUS;
                strobe_next = 1'b1;
                state_next  = EM_DIGIT;
            end
            EM_DIGIT:
            begin
                char_next   = CODE_ZERO + {4'd0, top_digit};
                strobe_next = 1'b1;
                last_next   = (cnt_reg == 4'd1);
                dig_next    = {dig_reg[BCD_W-5:0], 4'd0};
                cnt_next    = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                    state_next = EM_IDLE;
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EM_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
    end

    assign char_code = char_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

    // every emitted character is a minus sign or a decimal digit
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (char_reg == CODE_MINUS ||
                        (char_reg >= CODE_ZERO && char_reg <= CODE_ZERO + 8'd9)))
        else $error("illegal character emitted");

    // a minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && char_reg == CODE_MINUS) |-> !last_reg)
        else $error("minus sign flagged as last");

    // a new conversion only arrives while the emitter is idle
    a_conv_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        conv.valid |-> state_reg == EM_IDLE)
        else $error("conversion arrived while emitting");

endmodule

>>> hdl/signed_int_to_decimal_ascii_unit.sv
// ============================================================================
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per strobe, most significant first, with a leading minus when negative.
// ============================================================================
//
//  channel   handshake          payload              direction
//  request   start / busy       value[31:0] signed   in
//  result    strobe             char_code[7:0], last out
//
// - a request is taken at a clock edge with start high and busy low
// - the magnitude goes through a 32-step bit-serial shift-add to BCD, one
//   bit per cycle, then leading zeros are dropped one digit per cycle
// - while busy, a request passes through the 32 conversion steps, a
//   hand-over to the emitter, the zero dropping, the sign when negative,
//   the digit output (each dropped zero takes the place of a digit) and
//   the release of busy
// - busy stays high until the cycle after the strobe that carries last
// - reset clears all control state; results cannot be stalled
//
module signed_int_to_decimal_ascii_unit
    import sitda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic [CHAR_W-1:0]  char_code,
    output logic               last,
    output logic               strobe
);

    logic         busy_reg, busy_next;
    logic         accept;
    conv_result_t conv;

    assign accept = start && !busy_reg;

    // busy from accept until the final character has gone out
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (strobe && last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    assign busy = busy_reg;

    // serial binary to BCD
    sitda_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .value  (value),
        .result (conv)
    );

    // character sequencing
    sitda_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv      (conv),
        .char_code (char_code),
        .last      (last),
        .strobe    (strobe)
    );

    // characters only appear while a request is in progress
    a_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy_reg)
        else $error("character emitted outside a request");

    // an accepted request holds busy
    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after accept");

    // the final character releases the unit
    a_last_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy_reg)
        else $error("busy not released after final character");

endmodule

>>> verif/tb_signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_signed_int_to_decimal_ascii_unit
// Self-checking bench for the signed integer to decimal text unit. Requests
// come from a queue of directed and random values. A predictor turns each
// accepted value into its expected character stream, and every strobed
// character is checked in order against it.
// ============================================================================
module tb_signed_int_to_decimal_ascii_unit;
    import sitda_pkg::*;

    localparam int RADIX          = 10;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 100;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    // one character of expected text
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic [CHAR_W-1:0]  char_code;
    logic               last;
    logic               strobe;

    logic [VALUE_W-1:0] pending_values[$];
    text_char_t         expected_text[$];

    int requests_taken = 0;
    int negatives_taken = 0;
    int chars_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    signed_int_to_decimal_ascii_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .char_code (char_code),
        .last      (last),
        .strobe    (strobe)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // mismatch reporting
    task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] exp_val,
                                   input logic [CHAR_W-1:0] got_val);
        begin
            mismatches++;
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what,
                     exp_val, got_val);
        end
    endtask

    // decimal text of one value, queued as expected characters
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit_buf[DIGITS];
        int                 n;
        text_char_t         c;
        begin
            neg = v[VALUE_W-1];
            mag = neg ? (~v + 1'b1) : v;
            n = 0;
            do
            begin
                digit_buf[n] = 4'(mag % RADIX);
                mag = mag / RADIX;
                n++;
            end while (mag != 0 && n < DIGITS);
            if (neg)
            begin
                c.code = CODE_MINUS;
                c.last = 1'b0;
                expected_text.push_back(c);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                c.code = CODE_ZERO + {4'd0, digit_buf[i]};
                c.last = (i == 0);
                expected_text.push_back(c);
            end
        end
    endfunction

    // sender idling per phase: light, heavy, then none
    function automatic bit sender_idles();
        int pct;
        begin
            if (requests_taken < 40)
                pct = 10;
            else if (requests_taken < 80)
                pct = 45;
            else
                pct = 0;
            return $urandom_range(0, 99) < pct;
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_text(value);
                requests_taken++;
                if (value[VALUE_W-1])
                    negatives_taken++;
                if (pending_values.size() != 0 && !sender_idles())
                begin
                    start <= 1'b1;
                    value <= pending_values.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    value <= $urandom;
                end
            end
            else if (!start && pending_values.size() != 0 && !sender_idles())
            begin
                start <= 1'b1;
                value <= pending_values.pop_front();
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n && strobe)
        begin
            if (expected_text.size() == 0)
            begin
                report_mismatch("character with no text pending", '0, char_code);
            end
            else
            begin
                exp_c = expected_text.pop_front();
                chars_checked++;
                if (char_code !== exp_c.code)
                    report_mismatch("char_code", exp_c.code, char_code);
                if (last !== exp_c.last)
                    report_mismatch("last", {7'd0, exp_c.last}, {7'd0, last});
            end
        end
    end

    // watchdog on cycles with neither a request nor a character taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d characters outstanding",
                         expected_text.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [VALUE_W-1:0] v;
        int                 kind;
        int                 ndig;
        int                 zeros;
        longint unsigned    span;

        // directed: zero, digit boundaries, extremes, trailing zeros
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(-32'sd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(32'd100);
        pending_values.push_back(32'd50);
        pending_values.push_back(-32'sd70000);
        pending_values.push_back(32'd999999999);
        pending_values.push_back(32'd1000000000);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'd2000000000);
        pending_values.push_back(32'd1234567890);
        pending_values.push_back(-32'sd987654321);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'hFFFF_FFF6);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);

        // random: full words, chosen lengths, and runs of trailing zeros
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 2);
            if (kind == 0)
                v = $urandom;
            else
            begin
                ndig = $urandom_range(1, DIGITS);
                if (ndig == DIGITS)
                    v = $urandom & 32'h7FFF_FFFF;
                else
                begin
                    span = 1;
                    for (int k = 0; k < ndig; k++)
                        span = span * RADIX;
                    v = $urandom_range(0, 32'(span - 1));
                end
                if (kind == 2)
                begin
                    zeros = $urandom_range(1, 6);
                    for (int k = 0; k < zeros; k++)
                        v = v * RADIX;
                end
                if ($urandom_range(0, 1))
                    v = ~v + 1'b1;
            end
            pending_values.push_back(v);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || start)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("converted %0d values (%0d negative), checked %0d characters",
                 requests_taken, negatives_taken, chars_checked);
        $display("covered zero, both extremes, all lengths and trailing zeros");
        if (mismatches == 0 && expected_text.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> signed_int_to_decimal_ascii_unit.f
hdl/sitda_pkg.sv
hdl/sitda_dabble.sv
hdl/sitda_emitter.sv
hdl/signed_int_to_decimal_ascii_unit.sv
verif/tb_signed_int_to_decimal_ascii_unit.sv
